/* sv/swrs_pkg.sv */
// ----------------------------------------------------------------------------
// swrs_pkg
// Types and constants shared by the sliding window range sum block.
// ----------------------------------------------------------------------------
package swrs_pkg;

    localparam int STORE_DEPTH_DEFAULT = 1024;

    localparam int DATA_W   = 16;
    localparam int IDX_W    = 10;
    localparam int POS_W    = 11;
    localparam int SUM_W    = 27;
    localparam int RESULT_W = 26;

    localparam logic [POS_W-1:0] ARRAY_LENGTH_RESET = 11'd1024;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic [IDX_W-1:0]           element_index;
        logic signed [DATA_W-1:0]   element_value;
        logic [IDX_W-1:0]           query_left;
        logic [IDX_W-1:0]           query_right;
    } request_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] range_sum;
        logic                       range_error;
    } result_t;

endpackage

/* sv/sliding_window_range_sum.sv */
// ----------------------------------------------------------------------------
// sliding_window_range_sum
// Range-sum queries over a loaded element store, answered by walking a kept
// window one element per cycle and updating a running sum.
// ----------------------------------------------------------------------------
// a load beat is taken while idle and does not stall the input; a rejected query
// goes straight to the finish state, which registers its result once the output is free
// a good query first walks the window, one element store read per cycle, so
// the rate follows the distance between successive queries
// the next beat is taken once the result sits in the output register
// reset empties the window and sets array_length to 1024; the store is not
// cleared and holds garbage until loaded
module sliding_window_range_sum #(
    parameter int STORE_DEPTH = swrs_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  swrs_pkg::request_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output swrs_pkg::result_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swrs_pkg::POS_W-1:0]        cfg_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W = swrs_pkg::POS_W;
    localparam int SUM_W = swrs_pkg::SUM_W;
    localparam int DATA_W = swrs_pkg::DATA_W;
    localparam int RESULT_W = swrs_pkg::RESULT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // element store
    logic [DATA_W-1:0] mem [STORE_DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= in_data.element_value;
        end
        rdata_reg <= mem[mem_raddr];
    end

    state_t                    state_reg, state_next;
    logic [POS_W-1:0]          array_length_reg;
    logic [POS_W-1:0]          wl_reg, wl_next;
    logic [POS_W-1:0]          we_reg, we_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [POS_W-1:0]          q_left_reg, q_left_next;
    logic [POS_W-1:0]          q_end_reg, q_end_next;
    logic                      q_err_reg, q_err_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      pend_sub_reg, pend_sub_next;
    logic                      out_valid_reg, out_valid_next;
    swrs_pkg::result_t         out_data_reg, out_data_next;

    logic                      in_accept;
    logic                      load_ok;
    logic                      query_bad;
    logic [POS_W-1:0]          move_pos;
    logic [SUM_W-1:0]          elem_ext;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign load_ok   = 32'(in_data.element_index) < 32'(STORE_DEPTH);
    assign query_bad = (in_data.query_left > in_data.query_right)
                    || (POS_W'(in_data.query_right) >= array_length_reg)
                    || (32'(in_data.query_right) >= 32'(STORE_DEPTH));

    assign mem_we    = in_accept && (in_data.opcode == swrs_pkg::OP_LOAD) && load_ok;
    assign mem_waddr = AW'(in_data.element_index);
    assign mem_raddr = AW'(move_pos);

    assign elem_ext = {{(SUM_W - DATA_W){rdata_reg[DATA_W-1]}}, rdata_reg};

    always_comb
    begin
        state_next      = state_reg;
        wl_next         = wl_reg;
        we_next         = we_reg;
        sum_next        = sum_reg;
        q_left_next     = q_left_reg;
        q_end_next      = q_end_reg;
        q_err_next      = q_err_reg;
        pend_valid_next = 1'b0;
        pend_sub_next   = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        move_pos        = wl_reg;

        // element read last cycle lands in the sum now
        if (pend_valid_reg)
        begin
            sum_next = pend_sub_reg ? (sum_reg - elem_ext) : (sum_reg + elem_ext);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.opcode == swrs_pkg::OP_LOAD)
                    begin
                        if (load_ok)
                        begin
                            wl_next  = '0;
                            we_next  = '0;
                            sum_next = '0;
                        end
                    end
                    else
                    begin
                        q_left_next = POS_W'(in_data.query_left);
                        q_end_next  = POS_W'(in_data.query_right) + POS_W'(1);
                        q_err_next  = query_bad;
                        state_next  = query_bad ? ST_FINISH : ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // left edge first, then right edge, one element per cycle
                if (wl_reg < q_left_reg)
                begin
                    move_pos        = wl_reg;
                    wl_next         = wl_reg + POS_W'(1);
                    pend_valid_next = 1'b1;
                    pend_sub_next   = 1'b1;
                end
                else if (wl_reg > q_left_reg)
                begin
                    move_pos        = wl_reg - POS_W'(1);
                    wl_next         = wl_reg - POS_W'(1);
                    pend_valid_next = 1'b1;
                end
                else if (we_reg < q_end_reg)
                begin
                    move_pos        = we_reg;
                    we_next         = we_reg + POS_W'(1);
                    pend_valid_next = 1'b1;
                end
                else if (we_reg > q_end_reg)
                begin
                    move_pos        = we_reg - POS_W'(1);
                    we_next         = we_reg - POS_W'(1);
                    pend_valid_next = 1'b1;
                    pend_sub_next   = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.range_error = q_err_reg;
                    out_data_next.range_sum   = q_err_reg ? '0
                                                          : sum_reg[RESULT_W-1:0];
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            array_length_reg <= swrs_pkg::ARRAY_LENGTH_RESET;
            wl_reg           <= '0;
            we_reg           <= '0;
            sum_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_sub_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wl_reg         <= wl_next;
            we_reg         <= we_next;
            sum_reg        <= sum_next;
            pend_valid_reg <= pend_valid_next;
            pend_sub_reg   <= pend_sub_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                array_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_left_reg   <= q_left_next;
        q_end_reg    <= q_end_next;
        q_err_reg    <= q_err_next;
        out_data_reg <= out_data_next;
    end

    // a pending sum update always comes from a walk step
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("pending update without a walk step");

    // the window sits on the query when its result is built
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !q_err_reg) |->
            (wl_reg == q_left_reg && we_reg == q_end_reg && !pend_valid_reg))
        else $error("window not settled at finish");

    // a rejected query reports a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.range_error) |-> (out_data_reg.range_sum == '0))
        else $error("error result with nonzero sum");

    // a load empties the window
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (wl_reg == '0 && we_reg == '0 && sum_reg == '0))
        else $error("window not emptied by load");

endmodule

/* tb/tb_sliding_window_range_sum.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_range_sum
// Self-checking bench for the sliding window range sum block. Loads and
// range queries are driven from a queue, every taken beat is run through a
// shadow copy of the window walk, and each result beat is checked field by
// field against the oldest predicted sum.
// ----------------------------------------------------------------------------
module tb_sliding_window_range_sum;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int DEPTH        = swrs_pkg::STORE_DEPTH_DEFAULT;
    localparam int MAX_REPORTS  = 20;
    localparam int DATA_W       = swrs_pkg::DATA_W;
    localparam int IDX_W        = swrs_pkg::IDX_W;
    localparam int POS_W        = swrs_pkg::POS_W;
    localparam int SUM_W        = swrs_pkg::SUM_W;
    localparam int RESULT_W     = swrs_pkg::RESULT_W;
    localparam int REQ_W        = $bits(swrs_pkg::request_t);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    swrs_pkg::request_t in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    swrs_pkg::result_t  out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [POS_W-1:0]   cfg_data  = '0;

    // shadow of the block state
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    logic [POS_W-1:0]         win_lo;
    logic [POS_W-1:0]         win_hi;
    logic [SUM_W-1:0]         window_sum;
    logic [POS_W-1:0]         cur_length;

    swrs_pkg::request_t pending_requests [$];
    swrs_pkg::result_t  expected_sums [$];

    bit  idling_on = 1'b1;
    int  gap_left;
    int  hold_left;
    int  error_count;
    int  load_count;
    int  query_count;
    int  reject_count;
    int  length_writes;
    int  sums_checked;
    longint cycle_count;

    sliding_window_range_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [SUM_W-1:0] widen(input logic signed [DATA_W-1:0] v);
        return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // walk the shadow window to the query, as the block does
    task automatic apply_request(input swrs_pkg::request_t req);
        swrs_pkg::result_t res;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi_end;
        begin
            if (req.opcode == swrs_pkg::OP_LOAD)
            begin
                shadow_store[req.element_index] = req.element_value;
                win_lo     = '0;
                win_hi     = '0;
                window_sum = '0;
                load_count++;
            end
            else
            begin
                query_count++;
                lo     = {1'b0, req.query_left};
                hi_end = {1'b0, req.query_right} + 1'b1;
                if (req.query_left > req.query_right ||
                    {1'b0, req.query_right} >= cur_length)
                begin
                    res.range_sum   = '0;
                    res.range_error = 1'b1;
                    reject_count++;
                end
                else
                begin
                    while (win_lo < lo)
                    begin
                        window_sum = window_sum - widen(shadow_store[win_lo[IDX_W-1:0]]);
                        win_lo     = win_lo + 1'b1;
                    end
                    while (win_lo > lo)
                    begin
                        win_lo     = win_lo - 1'b1;
                        window_sum = window_sum + widen(shadow_store[win_lo[IDX_W-1:0]]);
                    end
                    while (win_hi < hi_end)
                    begin
                        window_sum = window_sum + widen(shadow_store[win_hi[IDX_W-1:0]]);
                        win_hi     = win_hi + 1'b1;
                    end
                    while (win_hi > hi_end)
                    begin
                        win_hi     = win_hi - 1'b1;
                        window_sum = window_sum - widen(shadow_store[win_hi[IDX_W-1:0]]);
                    end
                    res.range_sum   = window_sum[RESULT_W-1:0];
                    res.range_error = 1'b0;
                end
                expected_sums.push_back(res);
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_request(in_data);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 && idling_on &&
                         $urandom_range(0, 5) == 0)
                begin
                    gap_left <= $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                sums_checked++;
                if (expected_sums.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result beat, expected none, got sum %0d err %0b",
                                 $time, out_data.range_sum, out_data.range_error);
                end
                else
                begin
                    swrs_pkg::result_t want;
                    want = expected_sums.pop_front();
                    if (out_data.range_sum !== want.range_sum ||
                        out_data.range_error !== want.range_error)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch, expected sum %0d err %0b, got sum %0d err %0b",
                                     $time, want.range_sum, want.range_error,
                                     out_data.range_sum, out_data.range_error);
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d sums still expected",
                     cycle_count, expected_sums.size());
            $display("FAIL sliding_window_range_sum");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic push_load(input int idx, input logic signed [DATA_W-1:0] val);
        swrs_pkg::request_t req;
        begin
            req               = swrs_pkg::request_t'(REQ_W'({$urandom, $urandom}));
            req.opcode        = swrs_pkg::OP_LOAD;
            req.element_index = IDX_W'(idx);
            req.element_value = val;
            pending_requests.push_back(req);
        end
    endtask

    task automatic push_query(input int lo, input int hi);
        swrs_pkg::request_t req;
        begin
            req             = swrs_pkg::request_t'(REQ_W'({$urandom, $urandom}));
            req.opcode      = swrs_pkg::OP_QUERY;
            req.query_left  = IDX_W'(lo);
            req.query_right = IDX_W'(hi);
            pending_requests.push_back(req);
        end
    endtask

    // block idle: nothing queued, nothing in flight, load latency covered
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (pending_requests.size() != 0 || in_valid || expected_sums.size() != 0);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic write_length(input int len);
        begin
            wait_drained();
            cfg_valid <= 1'b1;
            cfg_data  <= POS_W'(len);
            do
                @(posedge clk);
            while (!cfg_ready);
            cur_length = POS_W'(len);
            length_writes++;
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        int fl;
        int fr;
        int a;
        int b;
        int len_pick;

        cur_length = swrs_pkg::ARRAY_LENGTH_RESET;
        win_lo     = '0;
        win_hi     = '0;
        window_sum = '0;
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: value extremes in a small written region
        push_load(0, 16'sh7fff);
        push_load(1, 16'sh7fff);
        push_load(2, 16'sh8000);
        push_load(3, 16'sh8000);
        push_load(4, -16'sd1);
        push_load(5, 16'sd1);
        push_load(6, 16'sd0);
        push_load(7, 16'sd12345);
        push_query(0, 7);
        push_query(0, 1);
        push_query(6, 7);       // left edge passes the old end
        push_query(2, 3);
        push_query(0, 0);
        push_query(7, 7);
        push_query(1023, 0);    // left above right
        push_query(3, 3);
        push_load(6, 16'sh8000); // load empties the window
        push_query(4, 6);

        write_length(8);
        push_query(0, 7);
        push_query(0, 8);       // right beyond array length
        write_length(0);        // every query rejected
        push_query(0, 0);
        write_length(1);
        push_query(0, 0);
        push_query(0, 1);

        // fill the rest of the store in order, querying only loaded entries
        write_length(2047);
        for (int p = 8; p < DEPTH; p++)
        begin
            push_load(p, pick_value());
            if ($urandom_range(0, 15) == 0)
            begin
                b = $urandom_range(0, p);
                push_query($urandom_range(0, b), b);
            end
        end

        // mixed traffic of loads and queries, many of them local window moves
        fl = 0;
        fr = 0;
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            case (chunk)
                0:       len_pick = 1024;
                1:       len_pick = $urandom_range(2, 1023);
                2:       len_pick = 2047;
                3:       len_pick = $urandom_range(512, 1023);
                default: len_pick = 1024;
            endcase
            write_length(len_pick);
            idling_on = (chunk != 4);
            for (int n = 0; n < 24; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                        push_load($urandom_range(0, DEPTH - 1), pick_value());
                    2, 3, 4, 5:
                    begin
                        a = fl + $urandom_range(0, 16) - 8;
                        b = fr + $urandom_range(0, 16) - 8;
                        a = (a < 0) ? 0 : (a > DEPTH - 1) ? DEPTH - 1 : a;
                        b = (b < 0) ? 0 : (b > DEPTH - 1) ? DEPTH - 1 : b;
                        if (a > b)
                        begin
                            fl = b;
                            fr = a;
                        end
                        else
                        begin
                            fl = a;
                            fr = b;
                        end
                        push_query(fl, fr);
                    end
                    6:
                    begin
                        fr = $urandom_range(0, DEPTH - 1);
                        fl = $urandom_range(0, fr);
                        push_query(fl, fr);
                    end
                    7:
                    begin
                        a = $urandom_range(1, DEPTH - 1);
                        push_query(a, $urandom_range(0, a - 1));
                    end
                    8:
                    begin
                        fl = $urandom_range(0, DEPTH - 1);
                        fr = fl;
                        push_query(fl, fr);
                    end
                    default:
                    begin
                        fl = $urandom_range(0, 15);
                        fr = DEPTH - 1 - $urandom_range(0, 15);
                        push_query(fl, fr);
                    end
                endcase
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);

        if (expected_sums.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected sums never arrived", $time, expected_sums.size());
        end
        $display("covered %0d loads and %0d queries (%0d rejected), %0d results checked",
                 load_count, query_count, reject_count, sums_checked);
        $display("array length written %0d times, %0d errors", length_writes, error_count);
        if (error_count == 0)
            $display("PASS sliding_window_range_sum");
        else
            $display("FAIL sliding_window_range_sum");
        $finish;
    end

endmodule

/* filelist.f */
sv/swrs_pkg.sv
sv/sliding_window_range_sum.sv
tb/tb_sliding_window_range_sum.sv
